[src/orbe_pkg.sv]
// ----------------------------------------------------------------------------
// orbe_pkg
// shared widths, cordic arctangent table and helpers for the best-edge block
// ----------------------------------------------------------------------------
package orbe_pkg;

  localparam int CoordW       = 24;
  localparam int SizeW        = 22;
  localparam int AngW         = 16;
  localparam int DirW         = 16;
  localparam int CordW        = 34;  // q2.30 plus headroom
  localparam int ZW           = 34;
  localparam int TrigW        = 18;  // cos/sin, 16 fraction bits
  localparam int AtanEntries  = 24;
  localparam int DefCordicSteps = 16;
  localparam int DefFracBits  = 8;
  localparam logic signed [CordW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [CoordW-1:0] CoordMax = 24'sh7FFFFF;
  localparam logic signed [CoordW-1:0] CoordMin = -24'sh800000;

  typedef struct packed {
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic [SizeW-1:0]         box_width;
    logic [SizeW-1:0]         box_height;
    logic [AngW-1:0]          angle;
    logic signed [DirW-1:0]   dir_x;
    logic signed [DirW-1:0]   dir_y;
  } orbe_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] vertex_x;
    logic signed [CoordW-1:0] vertex_y;
    logic signed [CoordW-1:0] edge_start_x;
    logic signed [CoordW-1:0] edge_start_y;
    logic signed [CoordW-1:0] edge_end_x;
    logic signed [CoordW-1:0] edge_end_y;
  } orbe_out_t;

  // angle-prepared word handed from front to back
  typedef struct packed {
    orbe_in_t               item;
    logic                   flip;
    logic signed [ZW-1:0]   z;
  } orbe_job_t;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      5'd0: v = 34'sd536870912;  5'd1: v = 34'sd316933406;
      5'd2: v = 34'sd167458907;  5'd3: v = 34'sd85004756;
      5'd4: v = 34'sd42667331;   5'd5: v = 34'sd21354465;
      5'd6: v = 34'sd10679838;   5'd7: v = 34'sd5340245;
      5'd8: v = 34'sd2670163;    5'd9: v = 34'sd1335087;
      5'd10: v = 34'sd667544;    5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;    5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;     5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;     5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;       5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;       5'd23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [CoordW-1:0] clamp24(input logic signed [CoordW+1:0] v);
    if (v > CoordW'(CoordMax) && v > 26'sd8388607) return CoordMax;
    if (v < -26'sd8388608) return CoordMin;
    return v[CoordW-1:0];
  endfunction

endpackage

[src/orbe_if.sv]
// ----------------------------------------------------------------------------
// orbe_if
// valid/ready channel carrying one payload word
// ----------------------------------------------------------------------------
interface orbe_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/oriented_rect_best_edge.sv]
// ----------------------------------------------------------------------------
// oriented_rect_best_edge
// furthest corner of a rotated rectangle along a direction, plus best edge
// ----------------------------------------------------------------------------
// channel  dir   fields
// in       sink  center_x/y, box_width/height, angle, dir_x/y
// out      src   vertex_x/y, edge_start_x/y, edge_end_x/y
//
// one word per cycle sustained while out is not stalled; words pass the
// front register, the two-entry queue, one cordic micro-rotation per stage,
// then rounding, products, corners, projection, edge vectors, dots, compare
// synchronous active-low reset clears valid state only
// out stall freezes the back pipeline; the queue absorbs the front word
module oriented_rect_best_edge import orbe_pkg::*; #(
  parameter int CORDIC_STEPS = DefCordicSteps
) (
  input logic clk,
  input logic rst_n,
  orbe_if.sink   in_ch,
  orbe_if.source out_ch
);
  // front -> queue
  logic      f_valid, f_ready;
  orbe_job_t f_data;
  // queue -> back
  logic      q_valid, q_ready;
  orbe_job_t q_data;

  orbe_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .job_valid(f_valid), .job_ready(f_ready), .job_data(f_data)
  );

  orbe_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  orbe_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst_n,
    .job_valid(q_valid), .job_ready(q_ready), .job_data(q_data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );
endmodule

[src/orbe_front.sv]
// ----------------------------------------------------------------------------
// orbe_front
// takes input words, folds the angle into a quarter turn, registers the job
// ----------------------------------------------------------------------------
module orbe_front import orbe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  orbe_in_t  in_data,
  output logic      job_valid,
  input  logic      job_ready,
  output orbe_job_t job_data
);
  logic               vld_r;
  orbe_job_t          job_r;
  logic signed [AngW:0] a;
  logic signed [AngW:0] af;
  logic               flip;

  assign in_ready = !vld_r || job_ready;

  always_comb begin
    a = {in_data.angle[AngW-1], in_data.angle};
    af = a;
    flip = 1'b0;
    if (a > 17'sd16384) begin
      af = a - 17'sd32768;
      flip = 1'b1;
    end else if (a < -17'sd16384) begin
      af = a + 17'sd32768;
      flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      job_r.item <= in_data;
      job_r.flip <= flip;
      job_r.z    <= {{(ZW-AngW-17){af[AngW]}}, af, 16'd0};
    end
  end

  assign job_valid = vld_r;
  assign job_data  = job_r;
endmodule

[src/orbe_fifo.sv]
// ----------------------------------------------------------------------------
// orbe_fifo
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module orbe_fifo import orbe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  orbe_job_t wr_data,
  output logic      rd_valid,
  input  logic      rd_ready,
  output orbe_job_t rd_data
);
  orbe_job_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
    if (wr) mem_r[wp_r] <= wr_data;
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count overflow");
  a_nooverrd: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !rd) else $error("read from empty queue");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !rd) |=> cnt_r == 2'd2) else $error("full queue lost entry");
endmodule

[src/orbe_back.sv]
// ----------------------------------------------------------------------------
// orbe_back
// pipelined cordic, corner build, projection and edge choice, output register
// ----------------------------------------------------------------------------
module orbe_back import orbe_pkg::*; #(
  parameter int CORDIC_STEPS = DefCordicSteps
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  output logic      job_ready,
  input  orbe_job_t job_data,
  output logic      out_valid,
  input  logic      out_ready,
  output orbe_out_t out_data
);
  localparam int NS = CORDIC_STEPS + 8; // entry + cordic + p0..p5 + output
  localparam int Last = NS - 1;
  // pipeline with global enable: advances when the tail is free
  logic adv;
  logic [NS-1:0] v_r;
  assign adv = !v_r[Last] || out_ready;
  assign job_ready = adv;

  // ---- cordic stages
  orbe_in_t             ci_r [CORDIC_STEPS+1];
  logic                 cf_r [CORDIC_STEPS+1];
  logic signed [CordW-1:0] cx_r [CORDIC_STEPS+1];
  logic signed [CordW-1:0] cy_r [CORDIC_STEPS+1];
  logic signed [ZW-1:0]    cz_r [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      ci_r[0] <= job_data.item;
      cf_r[0] <= job_data.flip;
      cx_r[0] <= CordicGain;
      cy_r[0] <= '0;
      cz_r[0] <= job_data.z;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cord
    logic signed [CordW-1:0] xs, ys;
    assign xs = cx_r[i] >>> i;
    assign ys = cy_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (adv) begin
        ci_r[i+1] <= ci_r[i];
        cf_r[i+1] <= cf_r[i];
        if (!cz_r[i][ZW-1]) begin
          cx_r[i+1] <= cx_r[i] - ys;
          cy_r[i+1] <= cy_r[i] + xs;
          cz_r[i+1] <= cz_r[i] - atan_lut(5'(i));
        end else begin
          cx_r[i+1] <= cx_r[i] + ys;
          cy_r[i+1] <= cy_r[i] - xs;
          cz_r[i+1] <= cz_r[i] + atan_lut(5'(i));
        end
      end
    end
  end

  // ---- p0: round cos/sin
  orbe_in_t p0_i_r;
  logic signed [TrigW-1:0] c_r, s_r;
  logic signed [CordW-1:0] xf, yf;
  assign xf = cf_r[CORDIC_STEPS] ? -cx_r[CORDIC_STEPS] : cx_r[CORDIC_STEPS];
  assign yf = cf_r[CORDIC_STEPS] ? -cy_r[CORDIC_STEPS] : cy_r[CORDIC_STEPS];
  always_ff @(posedge clk) begin
    if (adv) begin
      p0_i_r <= ci_r[CORDIC_STEPS];
      c_r <= TrigW'((xf + CordW'(8192)) >>> 14);
      s_r <= TrigW'((yf + CordW'(8192)) >>> 14);
    end
  end

  // ---- p1: four products c*w, s*h, s*w, c*h
  localparam int PW = TrigW + SizeW + 1;
  orbe_in_t p1_i_r;
  logic signed [PW-1:0] cw_r, sh_r, sw_r, ch_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_i_r <= p0_i_r;
      cw_r <= PW'(c_r) * PW'($signed({1'b0, p0_i_r.box_width}));
      sh_r <= PW'(s_r) * PW'($signed({1'b0, p0_i_r.box_height}));
      sw_r <= PW'(s_r) * PW'($signed({1'b0, p0_i_r.box_width}));
      ch_r <= PW'(c_r) * PW'($signed({1'b0, p0_i_r.box_height}));
    end
  end

  // ---- p2: corners, clamped
  localparam logic [3:0] SgnXNeg = 4'b1001; // corner k: x sign negative
  localparam logic [3:0] SgnYNeg = 4'b1100;
  orbe_in_t p2_i_r;
  logic signed [CoordW-1:0] px_r [4];
  logic signed [CoordW-1:0] py_r [4];
  for (genvar k = 0; k < 4; k++) begin : g_corner
    logic signed [PW+1:0] tx, ty, ex, ey;
    logic signed [CoordW+1:0] ox, oy;
    always_comb begin
      ex = SgnXNeg[k] ? -(PW+2)'(cw_r) : (PW+2)'(cw_r);
      ey = SgnYNeg[k] ? -(PW+2)'(sh_r) : (PW+2)'(sh_r);
      tx = ex - ey;
      ex = SgnXNeg[k] ? -(PW+2)'(sw_r) : (PW+2)'(sw_r);
      ey = SgnYNeg[k] ? -(PW+2)'(ch_r) : (PW+2)'(ch_r);
      ty = ex + ey;
      ox = (CoordW+2)'((tx + (PW+2)'(65536)) >>> 17);
      oy = (CoordW+2)'((ty + (PW+2)'(65536)) >>> 17);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        px_r[k] <= clamp24((CoordW+2)'(p1_i_r.center_x) + ox);
        py_r[k] <= clamp24((CoordW+2)'(p1_i_r.center_y) + oy);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) p2_i_r <= p1_i_r;
  end

  // ---- p3: projections
  localparam int DW = CoordW + DirW + 1;
  orbe_in_t p3_i_r;
  logic signed [CoordW-1:0] qx_r [4];
  logic signed [CoordW-1:0] qy_r [4];
  logic signed [DW-1:0] prj_r [4];
  for (genvar k = 0; k < 4; k++) begin : g_proj
    always_ff @(posedge clk) begin
      if (adv) begin
        prj_r[k] <= DW'(p2_i_r.dir_x) * DW'(px_r[k]) + DW'(p2_i_r.dir_y) * DW'(py_r[k]);
        qx_r[k] <= px_r[k];
        qy_r[k] <= py_r[k];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) p3_i_r <= p2_i_r;
  end

  // ---- p4: pick best corner, form edge vectors
  localparam int EW = CoordW + 1;
  logic [1:0] best;
  logic [1:0] b4_r;
  logic signed [EW-1:0] rxv_r, ryv_r, lxv_r, lyv_r;
  logic signed [CoordW-1:0] rx_r [4];
  logic signed [CoordW-1:0] ry_r [4];
  orbe_in_t p4_i_r;
  always_comb begin
    logic signed [DW-1:0] bp;
    bp = prj_r[0];
    best = 2'd0;
    for (int k = 1; k < 4; k++) begin
      if (prj_r[k] > bp) begin
        bp = prj_r[k];
        best = 2'(k);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      p4_i_r <= p3_i_r;
      b4_r   <= best;
      rx_r   <= qx_r;
      ry_r   <= qy_r;
      rxv_r  <= EW'(qx_r[best]) - EW'(qx_r[best - 2'd1]);
      ryv_r  <= EW'(qy_r[best]) - EW'(qy_r[best - 2'd1]);
      lxv_r  <= EW'(qx_r[best]) - EW'(qx_r[best + 2'd1]);
      lyv_r  <= EW'(qy_r[best]) - EW'(qy_r[best + 2'd1]);
    end
  end

  // ---- p5: dot with direction
  localparam int GW = EW + DirW + 1;
  logic signed [GW-1:0] dr_r, dl_r;
  logic [1:0] b5_r;
  logic signed [CoordW-1:0] sx_r [4];
  logic signed [CoordW-1:0] sy_r [4];
  logic [SizeW-1:0] lr5_r, ll5_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      dr_r <= GW'(p4_i_r.dir_x) * GW'(rxv_r) + GW'(p4_i_r.dir_y) * GW'(ryv_r);
      dl_r <= GW'(p4_i_r.dir_x) * GW'(lxv_r) + GW'(p4_i_r.dir_y) * GW'(lyv_r);
      b5_r <= b4_r;
      sx_r <= rx_r;
      sy_r <= ry_r;
      lr5_r <= b4_r[0] ? p4_i_r.box_width : p4_i_r.box_height;
      ll5_r <= b4_r[0] ? p4_i_r.box_height : p4_i_r.box_width;
    end
  end

  // ---- p6: cross-multiply, compare and select into output register
  localparam int MW = GW + SizeW + 1;
  logic signed [MW-1:0] ml, mr;
  logic pick;
  assign ml = MW'(dr_r) * MW'($signed({1'b0, ll5_r}));
  assign mr = MW'(dl_r) * MW'($signed({1'b0, lr5_r}));
  assign pick = ml <= mr;

  orbe_out_t o_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      o_r.vertex_x <= sx_r[b5_r];
      o_r.vertex_y <= sy_r[b5_r];
      if (pick) begin
        o_r.edge_start_x <= sx_r[b5_r - 2'd1];
        o_r.edge_start_y <= sy_r[b5_r - 2'd1];
        o_r.edge_end_x   <= sx_r[b5_r];
        o_r.edge_end_y   <= sy_r[b5_r];
      end else begin
        o_r.edge_start_x <= sx_r[b5_r];
        o_r.edge_start_y <= sy_r[b5_r];
        o_r.edge_end_x   <= sx_r[b5_r + 2'd1];
        o_r.edge_end_y   <= sy_r[b5_r + 2'd1];
      end
    end
  end

  // valid chain: CORDIC_STEPS+1 cordic regs, p0..p5, o_r
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NS-2:0], job_valid};
    end
  end

  assign out_valid = v_r[Last];
  assign out_data  = o_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[Last] && !out_ready) |=> v_r[Last] && $stable(o_r))
    else $error("result changed while stalled");
  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[Last] && !out_ready) |-> !job_ready) else $error("pipe moved while stalled");
  a_vtx: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[Last] |-> ((o_r.vertex_x == o_r.edge_start_x && o_r.vertex_y == o_r.edge_start_y)
                || (o_r.vertex_x == o_r.edge_end_x && o_r.vertex_y == o_r.edge_end_y)))
    else $error("edge does not touch vertex");
endmodule

[bench/orbe_checker.sv]
// ----------------------------------------------------------------------------
// orbe_checker
// watches both channels of the best-edge block, predicts each result word
// from the accepted input word and compares it field by field
// ----------------------------------------------------------------------------
module orbe_checker import orbe_pkg::*; #(
  parameter int CORDIC_STEPS = DefCordicSteps
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  orbe_in_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  orbe_out_t out_data,
  output int        fail_count,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  orbe_out_t expected_q[$];

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sat24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint arctan_step(int i);
    longint tbl[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    return tbl[i];
  endfunction

  // rotation-mode cordic, result rounded to 16 fraction bits
  function automatic void rotate_unit(input logic [AngW-1:0] ang, output longint c,
                                      output longint s);
    longint a, x, y, z, xs, ys;
    bit flip;
    a = longint'(signed'(ang));
    flip = 0;
    if (a > 16384) begin
      a -= 32768;
      flip = 1;
    end else if (a < -16384) begin
      a += 32768;
      flip = 1;
    end
    x = 652032874;
    y = 0;
    z = a * 65536;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = fshift(x, i);
      ys = fshift(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= arctan_step(i);
      end else begin
        x += ys; y -= xs; z += arctan_step(i);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = fshift(x + 8192, 14);
    s = fshift(y + 8192, 14);
  endfunction

  function automatic orbe_out_t best_edge(orbe_in_t w);
    longint c, s, cx, cy, bw, bh, dx, dy, ex, ey, p, best_p, dr, dl, len_r, len_l;
    longint px[4], py[4];
    int sx[4] = '{-1, 1, 1, -1};
    int sy[4] = '{1, 1, -1, -1};
    int best, nxt, prv;
    orbe_out_t r;
    rotate_unit(w.angle, c, s);
    cx = longint'(w.center_x);
    cy = longint'(w.center_y);
    bw = longint'(w.box_width);
    bh = longint'(w.box_height);
    dx = longint'(w.dir_x);
    dy = longint'(w.dir_y);
    for (int k = 0; k < 4; k++) begin
      ex = sx[k] * bw;
      ey = sy[k] * bh;
      px[k] = sat24(cx + fshift(c * ex - s * ey + 65536, 17));
      py[k] = sat24(cy + fshift(s * ex + c * ey + 65536, 17));
    end
    best = 0;
    best_p = dx * px[0] + dy * py[0];
    for (int k = 1; k < 4; k++) begin
      p = dx * px[k] + dy * py[k];
      if (p > best_p) begin
        best_p = p;
        best = k;
      end
    end
    nxt = (best + 1) & 3;
    prv = (best + 3) & 3;
    dr = dx * (px[best] - px[prv]) + dy * (py[best] - py[prv]);
    dl = dx * (px[best] - px[nxt]) + dy * (py[best] - py[nxt]);
    len_r = best[0] ? bw : bh;
    len_l = best[0] ? bh : bw;
    r.vertex_x = px[best][23:0];
    r.vertex_y = py[best][23:0];
    if (dr * len_l <= dl * len_r) begin
      r.edge_start_x = px[prv][23:0]; r.edge_start_y = py[prv][23:0];
      r.edge_end_x = px[best][23:0];  r.edge_end_y = py[best][23:0];
    end else begin
      r.edge_start_x = px[best][23:0]; r.edge_start_y = py[best][23:0];
      r.edge_end_x = px[nxt][23:0];    r.edge_end_y = py[nxt][23:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    orbe_out_t e;
    if (rst_n && in_valid && in_ready) expected_q.push_back(best_edge(in_data));
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("unexpected result word at %0t", $realtime);
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        if (out_data.vertex_x !== e.vertex_x)
          report_mismatch("vertex_x", out_data.vertex_x, e.vertex_x);
        if (out_data.vertex_y !== e.vertex_y)
          report_mismatch("vertex_y", out_data.vertex_y, e.vertex_y);
        if (out_data.edge_start_x !== e.edge_start_x)
          report_mismatch("edge_start_x", out_data.edge_start_x, e.edge_start_x);
        if (out_data.edge_start_y !== e.edge_start_y)
          report_mismatch("edge_start_y", out_data.edge_start_y, e.edge_start_y);
        if (out_data.edge_end_x !== e.edge_end_x)
          report_mismatch("edge_end_x", out_data.edge_end_x, e.edge_end_x);
        if (out_data.edge_end_y !== e.edge_end_y)
          report_mismatch("edge_end_y", out_data.edge_end_y, e.edge_end_y);
      end
    end
    pending = expected_q.size();
  end

endmodule

[bench/oriented_rect_best_edge_tb.sv]
// ----------------------------------------------------------------------------
// oriented_rect_best_edge_tb
// drives rotated rectangles and query directions into the best-edge block
// through directed corner cases and random phases with idling and stalls;
// the checker predicts and compares every result word
// ----------------------------------------------------------------------------
module oriented_rect_best_edge_tb import orbe_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = DefCordicSteps + 10;
  localparam int CycleLimit = 400000;

  logic clk = 0;
  logic rst_n = 0;
  int   fail_count;
  int   pending;
  int   cycle = 0;
  int   send_idle_pct = 0;   // sender idle chance, percent
  int   recv_stall_pct = 0;  // receiver stall chance, percent
  bit   hold_off = 0;        // long receiver hold-off in progress

  orbe_if #(.payload_t(orbe_in_t))  in_ch (clk);
  orbe_if #(.payload_t(orbe_out_t)) out_ch (clk);

  oriented_rect_best_edge u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  orbe_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .fail_count(fail_count), .pending(pending)
  );

  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls, forced low during a hold-off
  initial out_ch.ready = 0;
  always @(negedge clk)
    out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
  end

  // send one word, optional idle cycles first, hold until accepted
  task automatic push_word(input orbe_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic go_idle();
    in_ch.valid <= 0;
    @(negedge clk);
  endtask

  task automatic drain();
    go_idle();
    while (pending != 0) @(negedge clk);
  endtask

  function automatic orbe_in_t make_word(logic [23:0] cx, logic [23:0] cy,
      logic [21:0] bw, logic [21:0] bh, logic [15:0] ang, logic [15:0] dx,
      logic [15:0] dy);
    orbe_in_t w;
    w.center_x = cx; w.center_y = cy; w.box_width = bw; w.box_height = bh;
    w.angle = ang; w.dir_x = dx; w.dir_y = dy;
    return w;
  endfunction

  // mostly moderate boxes, sometimes full-range fields to hit saturation
  function automatic orbe_in_t rand_word();
    orbe_in_t w;
    w = make_word(24'($urandom), 24'($urandom), 22'($urandom), 22'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom));
    if ($urandom_range(3) != 0) begin
      w.center_x = $signed(24'($urandom_range(65535))) - 24'sd32768;
      w.center_y = $signed(24'($urandom_range(65535))) - 24'sd32768;
      w.box_width = 22'($urandom_range(8191));
      w.box_height = 22'($urandom_range(8191));
    end
    case ($urandom_range(9))
      0: w.angle = 16'($urandom_range(4)) << 14;  // quarter turns
      1: begin
        w.dir_x = 0;
        w.dir_y = 0;
      end
      2: w.box_width = w.box_height;               // square, ties likely
      3: w.box_height = 0;
      default: ;
    endcase
    return w;
  endfunction

  task automatic random_phase(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) push_word(rand_word());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: field extremes, quarter turns, angle fold edges, zero sizes,
    // zero direction, saturating corners
    push_word(make_word(24'd0, 24'd0, 22'd512, 22'd256, 16'd0, 16'sd16384, 16'sd0));
    push_word(make_word(24'd0, 24'd0, 22'd512, 22'd256, 16'd16384, 16'sd0, 16'sd16384));
    push_word(make_word(24'd0, 24'd0, 22'd512, 22'd256, 16'd32768, -16'sd16384, 16'sd0));
    push_word(make_word(24'd0, 24'd0, 22'd512, 22'd256, 16'd49152, 16'sd11585,
                        16'sd11585));
    push_word(make_word(24'd0, 24'd0, 22'd512, 22'd256, 16'd16385, 16'sd3, -16'sd7));
    push_word(make_word(24'd0, 24'd0, 22'd512, 22'd256, 16'd49151, 16'sd100, 16'sd1));
    push_word(make_word(24'd0, 24'd0, 22'd512, 22'd256, 16'd65535, 16'sd1, 16'sd1));
    push_word(make_word(24'h123456, 24'hfedcba, 22'd900, 22'd700, 16'd4000,
                        16'sd0, 16'sd0));
    push_word(make_word(24'd0, 24'd0, 22'd0, 22'd300, 16'd9000, 16'sd5000, -16'sd9000));
    push_word(make_word(24'd0, 24'd0, 22'd300, 22'd0, 16'd9000, -16'sd5000, 16'sd9000));
    push_word(make_word(24'd0, 24'd0, 22'd0, 22'd0, 16'd1234, 16'sd16384, 16'sd16384));
    push_word(make_word(24'h7fffff, 24'h7fffff, 22'h3fffff, 22'h3fffff, 16'd8192,
                        16'sh7fff, 16'sh7fff));
    push_word(make_word(24'h800000, 24'h800000, 22'h3fffff, 22'h3fffff, 16'd24576,
                        16'sh8000, 16'sh8000));
    push_word(make_word(24'h7fffff, 24'h800000, 22'h3fffff, 22'd1, 16'd0,
                        16'sh8000, 16'sh7fff));
    push_word(make_word(24'h800000, 24'h7fffff, 22'd1, 22'h3fffff, 16'd32767,
                        16'sh7fff, 16'sh8000));
    push_word(make_word(24'd0, 24'd0, 22'd1000, 22'd1000, 16'd0, 16'sd1, 16'sd0));
    push_word(make_word(24'd0, 24'd0, 22'd1000, 22'd1000, 16'd8192, 16'sd0, -16'sd1));

    // sender pauses until everything has come back
    drain();

    random_phase(450, 0, 0);
    random_phase(300, 82, 0);
    random_phase(300, 0, 82);
    random_phase(300, 23, 23);

    // long receiver hold-off while the sender keeps offering words
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1;
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      repeat (150) push_word(rand_word());
    join
    random_phase(150, 0, 0);

    drain();
    repeat (Latency + 10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
